// ===== rtl/core/gdfw_pkg.sv =====
package gdfw_pkg;

	// Graph size
	localparam int NODE_COUNT = 8;
	localparam int MAX_DEGREE = 4;

	// Derived widths
	localparam int NODE_W  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int SLOT_W  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
	localparam int CNT_W   = $clog2(MAX_DEGREE + 1);
	localparam int DEPTH_W = $clog2(NODE_COUNT + 1);

	// Fixed field widths of the stream ports
	localparam int FIELD_W = 3;

	// Request kinds carried on s_tuser
	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_ADD   = 2'd1,
		ACT_WALK  = 2'd2,
		ACT_NONE  = 2'd3
	} act_t;

	// Walk sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_EVAL,
		ST_FLUSH
	} state_t;

	// Update command to the adjacency store
	typedef struct packed {
		logic              clear;
		logic              add;
		logic [NODE_W-1:0] from_n;
		logic [NODE_W-1:0] to_n;
	} adj_cmd_t;

	// Slot read request to the adjacency store
	typedef struct packed {
		logic              en;
		logic [NODE_W-1:0] node;
		logic [SLOT_W-1:0] slot;
	} adj_rd_t;

endpackage

// ===== rtl/core/gdfw_adj_store.sv =====
module gdfw_adj_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  gdfw_pkg::adj_cmd_t        cmd,
	input  gdfw_pkg::adj_rd_t         rd,
	input  logic [gdfw_pkg::NODE_W-1:0] deg_node,
	output logic [gdfw_pkg::CNT_W-1:0]  deg,
	output logic [gdfw_pkg::NODE_W-1:0] rd_data
);
	import gdfw_pkg::*;

	// Adjacency slots, one row per node, undefined until written
	logic [NODE_W-1:0] nbr_mem [NODE_COUNT][MAX_DEGREE];
	// Fill level of each row
	logic [CNT_W-1:0]  deg_q [NODE_COUNT];
	logic [NODE_W-1:0] rd_data_q;

	// Degree of the requested node
	assign deg = deg_q[deg_node];

	// Degree counters: clear empties every list, add appends one slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODE_COUNT; i++) begin
				deg_q[i] <= '0;
			end
		end else if (cmd.clear) begin
			for (int i = 0; i < NODE_COUNT; i++) begin
				deg_q[i] <= '0;
			end
		end else if (cmd.add) begin
			deg_q[cmd.from_n] <= deg_q[cmd.from_n] + CNT_W'(1);
		end
	end

	// Slot memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.add) begin
			nbr_mem[cmd.from_n][deg_q[cmd.from_n][SLOT_W-1:0]] <= cmd.to_n;
		end
		if (rd.en) begin
			rd_data_q <= nbr_mem[rd.node][rd.slot];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/graph_depth_first_walker.sv =====
// Depth-first walker over a small directed graph held as per-node adjacency
// lists. A clear request empties every list, an add request appends an edge
// (error set when the source list is full or a node is out of range); both
// answer with one status result {node 0, tlast 1}. A walk request emits every
// node reachable from start_node in preorder, neighbours in insertion order,
// tlast on the final one; a start out of range gives no result. A walk reads
// each adjacency slot it examines from the adjacency memory and then evaluates
// its registered data, popping a stack frame when a list is exhausted; output
// back-pressure stalls the walk. Requests are taken only between walks.
module graph_depth_first_walker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // from_node[2:0], to_node[5:3], start_node[8:6], zero
	input  logic [1:0]  s_tuser,  // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // node[2:0], zero
	output logic        m_tlast,  // last
	output logic        m_tuser   // error[0]
);
	import gdfw_pkg::*;

	// Input fields
	logic [FIELD_W-1:0] from_f, to_f, start_f;
	act_t               act;
	assign from_f  = s_tdata[FIELD_W-1:0];
	assign to_f    = s_tdata[2*FIELD_W-1:FIELD_W];
	assign start_f = s_tdata[3*FIELD_W-1:2*FIELD_W];
	assign act     = act_t'(s_tuser);

	state_t state_q, state_d;

	// Walk state
	logic [NODE_COUNT-1:0] visited_q;
	logic [DEPTH_W-1:0]    depth_q;
	logic [NODE_W-1:0]     stk_node_q [NODE_COUNT];
	logic [CNT_W-1:0]      stk_slot_q [NODE_COUNT];
	logic [NODE_W-1:0]     pend_node_q;

	// Output register
	logic               out_valid_q;
	logic [FIELD_W-1:0] out_node_q;
	logic               out_last_q;
	logic               out_err_q;

	// Adjacency store interface
	adj_cmd_t          cmd;
	adj_rd_t           rd;
	logic [NODE_W-1:0] deg_node;
	logic [CNT_W-1:0]  deg;
	logic [NODE_W-1:0] nxt;

	// Decode
	logic              accept, out_free;
	logic              from_ok, to_ok, start_ok, add_ok;
	logic [NODE_W-1:0] from_i, to_i, start_i;
	logic [NODE_W-1:0] top_idx, push_idx, top_node;
	logic [CNT_W-1:0]  top_slot;
	logic              exhausted, nxt_new, emit, flush_out, can_push;

	gdfw_adj_store u_adj (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.rd       (rd),
		.deg_node (deg_node),
		.deg      (deg),
		.rd_data  (nxt)
	);

	// Request decode and walk conditions
	always_comb begin
		out_free  = !out_valid_q || m_tready;
		s_tready  = (state_q == ST_IDLE) && out_free;
		accept    = s_tvalid && s_tready;
		from_ok   = int'(from_f) < NODE_COUNT;
		to_ok     = int'(to_f) < NODE_COUNT;
		start_ok  = int'(start_f) < NODE_COUNT;
		from_i    = NODE_W'(from_f);
		to_i      = NODE_W'(to_f);
		start_i   = NODE_W'(start_f);
		top_idx   = NODE_W'(depth_q - DEPTH_W'(1));
		push_idx  = NODE_W'(depth_q);
		top_node  = stk_node_q[top_idx];
		top_slot  = stk_slot_q[top_idx];
		deg_node  = (state_q == ST_IDLE) ? from_i : top_node;
		add_ok    = from_ok && to_ok && (int'(deg) < MAX_DEGREE);
		exhausted = top_slot >= deg;
		nxt_new   = (int'(nxt) < NODE_COUNT) ? !visited_q[nxt] : 1'b0;
		emit      = (state_q == ST_EVAL) && nxt_new && out_free;
		flush_out = (state_q == ST_FLUSH) && out_free;
		can_push  = int'(depth_q) < NODE_COUNT;

		cmd.clear  = accept && (act == ACT_CLEAR);
		cmd.add    = accept && (act == ACT_ADD) && add_ok;
		cmd.from_n = from_i;
		cmd.to_n   = to_i;

		rd.en   = (state_q == ST_STEP) && !exhausted;
		rd.node = top_node;
		rd.slot = top_slot[SLOT_W-1:0];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (act == ACT_WALK) && start_ok) state_d = ST_STEP;
			end
			ST_STEP: begin
				priority if (!exhausted)                      state_d = ST_EVAL;
				else if (depth_q == DEPTH_W'(1))             state_d = ST_FLUSH;
				else                                         state_d = ST_STEP;
			end
			ST_EVAL: begin
				if (!nxt_new || out_free) state_d = ST_STEP;
			end
			ST_FLUSH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// Visited map and stack depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			depth_q   <= '0;
		end else begin
			if (accept && (act == ACT_WALK)) begin
				visited_q <= '0;
				depth_q   <= '0;
				if (start_ok) begin
					visited_q[start_i] <= 1'b1;
					depth_q            <= DEPTH_W'(1);
				end
			end else if ((state_q == ST_STEP) && exhausted) begin
				depth_q <= depth_q - DEPTH_W'(1);
			end else if (emit) begin
				visited_q[nxt] <= 1'b1;
				if (can_push) depth_q <= depth_q + DEPTH_W'(1);
			end
		end
	end

	// Stack frames and the held-back result
	always_ff @(posedge clk) begin
		if (accept && (act == ACT_WALK) && start_ok) begin
			stk_node_q[0] <= start_i;
			stk_slot_q[0] <= '0;
			pend_node_q   <= start_i;
		end else if (rd.en) begin
			stk_slot_q[top_idx] <= top_slot + CNT_W'(1);
		end else if (emit) begin
			pend_node_q <= nxt;
			if (can_push) begin
				stk_node_q[push_idx] <= nxt;
				stk_slot_q[push_idx] <= '0;
			end
		end
	end

	// Output register: status results, walk results one behind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && ((act == ACT_CLEAR) || (act == ACT_ADD))) || emit || flush_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && ((act == ACT_CLEAR) || (act == ACT_ADD))) begin
			out_node_q <= '0;
			out_last_q <= 1'b1;
			out_err_q  <= (act == ACT_ADD) && !add_ok;
		end else if (emit || flush_out) begin
			out_node_q <= FIELD_W'(pend_node_q);
			out_last_q <= flush_out;
			out_err_q  <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(8 - FIELD_W){1'b0}}, out_node_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_err_q;

endmodule

// ===== rtl/core/gdfw_checker.sv =====
module gdfw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);
	import gdfw_pkg::*;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("result changed while stalled");

	// A rejected edge is a status result
	a_err_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'd0))
		else $error("error flag on a non-status result");

	// A clear request answers in the next cycle
	a_clear_resp: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == ACT_CLEAR)
			|=> m_tvalid && m_tlast && !m_tuser && (m_tdata == 8'd0))
		else $error("clear request without status result");

	// No new request while a result is held
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("request taken while output blocked");

endmodule

bind graph_depth_first_walker gdfw_checker u_gdfw_checker (.*);

// ===== bench/graph_depth_first_walker_tb.sv =====
`timescale 1ns / 100ps

module graph_depth_first_walker_tb;
	import gdfw_pkg::*;

	localparam int RANDOM_ITEMS   = 400;
	localparam int HOLD_OFF_LEN   = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 120;

	// One result as the block should present it
	typedef struct packed {
		logic [2:0] node;
		logic       last;
		logic       error;
	} visit_t;

	// Keeps its own copy of the graph and predicts the results of each request
	class dfs_order_tracker;
		logic [2:0] adj_slot [NODE_COUNT][MAX_DEGREE];
		int         degree [NODE_COUNT];
		visit_t     due_visits[$];
		int         mismatches;

		function new();
			foreach (degree[i])
				degree[i] = 0;
			mismatches = 0;
		endfunction

		function int outstanding();
			return due_visits.size();
		endfunction

		// Preorder from start, neighbours in insertion order
		function void predict_preorder(logic [2:0] start);
			logic [2:0] stk_node [NODE_COUNT];
			int         stk_slot [NODE_COUNT];
			bit         seen [NODE_COUNT];
			logic [2:0] order[$];
			logic [2:0] top, nxt;
			int         depth;
			visit_t     v;
			foreach (seen[i])
				seen[i] = 1'b0;
			seen[start] = 1'b1;
			order.push_back(start);
			stk_node[0] = start;
			stk_slot[0] = 0;
			depth = 1;
			while (depth > 0) begin
				top = stk_node[depth-1];
				if (stk_slot[depth-1] >= degree[top]) begin
					depth--;
				end else begin
					nxt = adj_slot[top][stk_slot[depth-1]];
					stk_slot[depth-1]++;
					if (!seen[nxt]) begin
						seen[nxt] = 1'b1;
						order.push_back(nxt);
						if (depth < NODE_COUNT) begin
							stk_node[depth] = nxt;
							stk_slot[depth] = 0;
							depth++;
						end
					end
				end
			end
			foreach (order[i]) begin
				v.node  = order[i];
				v.last  = (i == order.size() - 1);
				v.error = 1'b0;
				due_visits.push_back(v);
			end
		endfunction

		// Accepted request: update the graph copy and queue what it yields
		function void note_request(act_t act, logic [2:0] from_n, logic [2:0] to_n,
				logic [2:0] start_n);
			visit_t v;
			v.node  = 3'd0;
			v.last  = 1'b1;
			v.error = 1'b0;
			case (act)
				ACT_CLEAR: begin
					foreach (degree[i])
						degree[i] = 0;
					due_visits.push_back(v);
				end
				ACT_ADD: begin
					if (degree[from_n] < MAX_DEGREE) begin
						adj_slot[from_n][degree[from_n]] = to_n;
						degree[from_n]++;
					end else begin
						v.error = 1'b1;
					end
					due_visits.push_back(v);
				end
				ACT_WALK: predict_preorder(start_n);
				default: ;
			endcase
		endfunction

		// Accepted result against the oldest expectation
		function void check_result(logic [2:0] node, logic last, logic error);
			visit_t want;
			if (due_visits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result node %0d last %0d error %0d",
						$time, node, last, error);
				return;
			end
			want = due_visits.pop_front();
			if (want.node !== node || want.last !== last || want.error !== error) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"%0t: mismatch, expected node %0d last %0d error %0d,",
						" got node %0d last %0d error %0d"},
						$time, want.node, want.last, want.error, node, last, error);
			end
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = ACT_CLEAR;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	dfs_order_tracker tracker = new();

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int requests_sent  = 0;
	int quiet_cycles   = 0;
	bit hold_req       = 1'b0;

	graph_depth_first_walker dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// Watch both handshakes; feed the tracker and the watchdog counter
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				tracker.note_request(act_t'(s_tuser), s_tdata[2:0], s_tdata[5:3],
					s_tdata[8:6]);
			if (m_tvalid && m_tready)
				tracker.check_result(m_tdata[2:0], m_tlast, m_tuser);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Watchdog
	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("Verification failed");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (HOLD_OFF_LEN) begin
					m_tready <= 1'b0;
					@(posedge clk);
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Offer one request and wait until it is taken; tvalid stays high afterwards
	task automatic send_request(act_t act, logic [2:0] from_n, logic [2:0] to_n,
			logic [2:0] start_n);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {7'd0, start_n, to_n, from_n};
		do
			@(posedge clk);
		while (!s_tready);
		if (act != ACT_NONE)
			requests_sent++;
	endtask

	function automatic logic [2:0] any_node();
		return 3'($urandom_range(7));
	endfunction

	// Well-formed burst: optional clear, a run of edges, then a few walks
	task automatic graph_session();
		int         n_adds, n_walks;
		logic [2:0] hub;
		hub = any_node();
		if ($urandom_range(1) == 1)
			send_request(ACT_CLEAR, any_node(), any_node(), any_node());
		n_adds = $urandom_range(14, 1);
		repeat (n_adds) begin
			// bias towards one source so that lists fill up now and then
			send_request(ACT_ADD, ($urandom_range(3) == 0) ? hub : any_node(),
				any_node(), any_node());
		end
		n_walks = $urandom_range(3, 1);
		repeat (n_walks)
			send_request(ACT_WALK, any_node(), any_node(), any_node());
	endtask

	initial begin
		int target;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty graph, full list, self-loop, duplicate, deep chain
		send_request(ACT_WALK, 3'd7, 3'd7, 3'd0);
		send_request(ACT_ADD, 3'd0, 3'd7, 3'd7);
		send_request(ACT_ADD, 3'd0, 3'd0, 3'd0);
		send_request(ACT_ADD, 3'd0, 3'd7, 3'd0);
		send_request(ACT_ADD, 3'd0, 3'd3, 3'd0);
		send_request(ACT_ADD, 3'd0, 3'd5, 3'd0);
		send_request(ACT_ADD, 3'd7, 3'd3, 3'd0);
		send_request(ACT_WALK, 3'd0, 3'd0, 3'd0);
		send_request(ACT_WALK, 3'd0, 3'd0, 3'd7);
		send_request(ACT_NONE, 3'd7, 3'd7, 3'd7);
		send_request(ACT_CLEAR, 3'd7, 3'd7, 3'd7);
		send_request(ACT_WALK, 3'd7, 3'd7, 3'd0);
		for (int i = 0; i < 7; i++)
			send_request(ACT_ADD, 3'(i), 3'(i + 1), 3'd0);
		send_request(ACT_ADD, 3'd7, 3'd0, 3'd0);
		send_request(ACT_WALK, 3'd0, 3'd0, 3'd0);
		send_request(ACT_WALK, 3'd0, 3'd0, 3'd7);
		send_request(ACT_NONE, 3'd0, 3'd0, 3'd0);

		// Random: four idling phases, the first opens with a long receiver hold-off
		target = requests_sent;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_req = 1'b1; end
				1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
				default: begin send_idle_pct = 10; recv_stall_pct = 10; end
			endcase
			target += RANDOM_ITEMS / 4;
			while (requests_sent < target) begin
				if ($urandom_range(99) < 80)
					graph_session();
				else
					send_request(act_t'($urandom_range(3)), any_node(), any_node(),
						any_node());
			end
		end
		s_tvalid <= 1'b0;
		@(posedge clk);

		// Drain
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.outstanding() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
